>>> rtl/arbb_pkg.sv
`default_nettype none
package arbb_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // full product, rounded product and exact corner sum widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int RND_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;

    // register map
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_A   = IDX_W'(0),
        REG_COEF_B   = IDX_W'(1),
        REG_COEF_C   = IDX_W'(2),
        REG_COEF_D   = IDX_W'(3),
        REG_OFFSET_X = IDX_W'(4),
        REG_OFFSET_Y = IDX_W'(5)
    } t_reg_idx;

    // pipeline depth, input register to output register
    localparam int NUM_STAGES = 7;

endpackage
`default_nettype wire

>>> rtl/arbb_in_if.sv
`default_nettype none
interface arbb_in_if import arbb_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] rect_x;
    logic signed [DATA_W-1:0] rect_y;
    logic signed [DATA_W-1:0] rect_width;
    logic signed [DATA_W-1:0] rect_height;

    modport source (output valid, output rect_x, output rect_y, output rect_width,
                    output rect_height, input ready);
    modport sink (input valid, input rect_x, input rect_y, input rect_width,
                  input rect_height, output ready);
endinterface
`default_nettype wire

>>> rtl/arbb_out_if.sv
`default_nettype none
interface arbb_out_if import arbb_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] box_x;
    logic signed [DATA_W-1:0] box_y;
    logic        [DATA_W-1:0] box_width;
    logic        [DATA_W-1:0] box_height;

    modport source (output valid, output box_x, output box_y, output box_width,
                    output box_height, input ready);
    modport sink (input valid, input box_x, input box_y, input box_width,
                  input box_height, output ready);
endinterface
`default_nettype wire

>>> rtl/affine_rect_bounding_box_core.sv
`default_nettype none
// Maps an axis-aligned rectangle through a 2D affine transform held in six
// signed Q16.16 registers (a, b, c, d, offset x, offset y, at byte addresses
// 0 to 20) and returns the bounding box of the four mapped corners. The block
// is a seven-stage pipeline: edge saturation, eight 32x32 multipliers, rounding,
// corner sums, saturation with pairwise min/max, final min/max, and the extent
// subtraction into the output register. An item enters every cycle unless the
// output stalls, and its result passes through each stage register in order;
// the rate is set by the fully pipelined multiplier stage. A stall at the output
// holds each stage in place and only fills bubbles upstream. The user must write
// registers only while no item is in flight; the block does not enforce it.
module affine_rect_bounding_box_core import arbb_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    arbb_in_if.sink            i_rect,
    arbb_out_if.source         o_box,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [ADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // rounding and saturation helpers
    function automatic logic signed [RND_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) << (FRAC_BITS - 1));
        return t[PROD_W-1:FRAC_BITS];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < SUM_W'(Q_MIN)) begin
            return Q_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_edge(input logic signed [DATA_W-1:0] p,
                                                           input logic signed [DATA_W-1:0] q);
        logic signed [DATA_W:0] s;
        s = {p[DATA_W-1], p} + {q[DATA_W-1], q};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // configuration registers
    logic signed [DATA_W-1:0] r_coef_a;
    logic signed [DATA_W-1:0] r_coef_b;
    logic signed [DATA_W-1:0] r_coef_c;
    logic signed [DATA_W-1:0] r_coef_d;
    logic signed [DATA_W-1:0] r_offset_x;
    logic signed [DATA_W-1:0] r_offset_y;
    t_reg_idx                 reg_idx;
    logic                     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a   <= Q_ONE;
            r_coef_b   <= '0;
            r_coef_c   <= '0;
            r_coef_d   <= Q_ONE;
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COEF_A:   r_coef_a   <= pwdata;
                REG_COEF_B:   r_coef_b   <= pwdata;
                REG_COEF_C:   r_coef_c   <= pwdata;
                REG_COEF_D:   r_coef_d   <= pwdata;
                REG_OFFSET_X: r_offset_x <= pwdata;
                REG_OFFSET_Y: r_offset_y <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_COEF_A:   prdata = r_coef_a;
            REG_COEF_B:   prdata = r_coef_b;
            REG_COEF_C:   prdata = r_coef_c;
            REG_COEF_D:   prdata = r_coef_d;
            REG_OFFSET_X: prdata = r_offset_x;
            REG_OFFSET_Y: prdata = r_offset_y;
            default:      prdata = '0;
        endcase
    end

    // per-stage valid and ready
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_rdy;
    logic [NUM_STAGES-1:0] load;

    always_comb begin
        stage_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_box.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
        load[0] = stage_rdy[0] && i_rect.valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            load[k] = stage_rdy[k] && r_vld[k-1];
        end
    end

    assign i_rect.ready = stage_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_vld[0] <= i_rect.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: rectangle edges, far edges saturated
    logic signed [DATA_W-1:0] r_s1_x0, r_s1_x1, r_s1_y0, r_s1_y1;

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_s1_x0 <= i_rect.rect_x;
            r_s1_y0 <= i_rect.rect_y;
            r_s1_x1 <= sat_edge(i_rect.rect_x, i_rect.rect_width);
            r_s1_y1 <= sat_edge(i_rect.rect_y, i_rect.rect_height);
        end
    end

    // stage 2: the eight full products
    logic signed [PROD_W-1:0] r_s2_ax0, r_s2_ax1, r_s2_cy0, r_s2_cy1;
    logic signed [PROD_W-1:0] r_s2_bx0, r_s2_bx1, r_s2_dy0, r_s2_dy1;

    always_ff @(posedge i_clk) begin
        if (load[1]) begin
            r_s2_ax0 <= PROD_W'(r_coef_a) * PROD_W'(r_s1_x0);
            r_s2_ax1 <= PROD_W'(r_coef_a) * PROD_W'(r_s1_x1);
            r_s2_cy0 <= PROD_W'(r_coef_c) * PROD_W'(r_s1_y0);
            r_s2_cy1 <= PROD_W'(r_coef_c) * PROD_W'(r_s1_y1);
            r_s2_bx0 <= PROD_W'(r_coef_b) * PROD_W'(r_s1_x0);
            r_s2_bx1 <= PROD_W'(r_coef_b) * PROD_W'(r_s1_x1);
            r_s2_dy0 <= PROD_W'(r_coef_d) * PROD_W'(r_s1_y0);
            r_s2_dy1 <= PROD_W'(r_coef_d) * PROD_W'(r_s1_y1);
        end
    end

    // stage 3: round to nearest, ties upward
    logic signed [RND_W-1:0] r_s3_ax0, r_s3_ax1, r_s3_cy0, r_s3_cy1;
    logic signed [RND_W-1:0] r_s3_bx0, r_s3_bx1, r_s3_dy0, r_s3_dy1;

    always_ff @(posedge i_clk) begin
        if (load[2]) begin
            r_s3_ax0 <= fx_round(r_s2_ax0);
            r_s3_ax1 <= fx_round(r_s2_ax1);
            r_s3_cy0 <= fx_round(r_s2_cy0);
            r_s3_cy1 <= fx_round(r_s2_cy1);
            r_s3_bx0 <= fx_round(r_s2_bx0);
            r_s3_bx1 <= fx_round(r_s2_bx1);
            r_s3_dy0 <= fx_round(r_s2_dy0);
            r_s3_dy1 <= fx_round(r_s2_dy1);
        end
    end

    // stage 4: exact corner sums, corners ordered (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    logic signed [SUM_W-1:0] r_s4_cx [4];
    logic signed [SUM_W-1:0] r_s4_cy [4];
    logic signed [SUM_W-1:0] n_s4_ox, n_s4_oy;

    assign n_s4_ox = SUM_W'(r_offset_x);
    assign n_s4_oy = SUM_W'(r_offset_y);

    always_ff @(posedge i_clk) begin
        if (load[3]) begin
            r_s4_cx[0] <= SUM_W'(r_s3_ax0) + SUM_W'(r_s3_cy0) + n_s4_ox;
            r_s4_cx[1] <= SUM_W'(r_s3_ax1) + SUM_W'(r_s3_cy0) + n_s4_ox;
            r_s4_cx[2] <= SUM_W'(r_s3_ax0) + SUM_W'(r_s3_cy1) + n_s4_ox;
            r_s4_cx[3] <= SUM_W'(r_s3_ax1) + SUM_W'(r_s3_cy1) + n_s4_ox;
            r_s4_cy[0] <= SUM_W'(r_s3_bx0) + SUM_W'(r_s3_dy0) + n_s4_oy;
            r_s4_cy[1] <= SUM_W'(r_s3_bx1) + SUM_W'(r_s3_dy0) + n_s4_oy;
            r_s4_cy[2] <= SUM_W'(r_s3_bx0) + SUM_W'(r_s3_dy1) + n_s4_oy;
            r_s4_cy[3] <= SUM_W'(r_s3_bx1) + SUM_W'(r_s3_dy1) + n_s4_oy;
        end
    end

    // stage 5: saturate corners, min/max within each pair
    logic signed [DATA_W-1:0] n_s5_cx [4];
    logic signed [DATA_W-1:0] n_s5_cy [4];
    logic signed [DATA_W-1:0] r_s5_minx [2];
    logic signed [DATA_W-1:0] r_s5_maxx [2];
    logic signed [DATA_W-1:0] r_s5_miny [2];
    logic signed [DATA_W-1:0] r_s5_maxy [2];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_s5_cx[i] = sat_sum(r_s4_cx[i]);
            n_s5_cy[i] = sat_sum(r_s4_cy[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[4]) begin
            for (int j = 0; j < 2; j++) begin
                r_s5_minx[j] <= (n_s5_cx[2*j+1] < n_s5_cx[2*j]) ? n_s5_cx[2*j+1] : n_s5_cx[2*j];
                r_s5_maxx[j] <= (n_s5_cx[2*j+1] > n_s5_cx[2*j]) ? n_s5_cx[2*j+1] : n_s5_cx[2*j];
                r_s5_miny[j] <= (n_s5_cy[2*j+1] < n_s5_cy[2*j]) ? n_s5_cy[2*j+1] : n_s5_cy[2*j];
                r_s5_maxy[j] <= (n_s5_cy[2*j+1] > n_s5_cy[2*j]) ? n_s5_cy[2*j+1] : n_s5_cy[2*j];
            end
        end
    end

    // stage 6: final min/max
    logic signed [DATA_W-1:0] r_s6_minx, r_s6_maxx, r_s6_miny, r_s6_maxy;

    always_ff @(posedge i_clk) begin
        if (load[5]) begin
            r_s6_minx <= (r_s5_minx[1] < r_s5_minx[0]) ? r_s5_minx[1] : r_s5_minx[0];
            r_s6_maxx <= (r_s5_maxx[1] > r_s5_maxx[0]) ? r_s5_maxx[1] : r_s5_maxx[0];
            r_s6_miny <= (r_s5_miny[1] < r_s5_miny[0]) ? r_s5_miny[1] : r_s5_miny[0];
            r_s6_maxy <= (r_s5_maxy[1] > r_s5_maxy[0]) ? r_s5_maxy[1] : r_s5_maxy[0];
        end
    end

    // stage 7: output register, extents wrap into unsigned
    logic signed [DATA_W-1:0] r_s7_box_x, r_s7_box_y;
    logic        [DATA_W-1:0] r_s7_box_width, r_s7_box_height;

    always_ff @(posedge i_clk) begin
        if (load[6]) begin
            r_s7_box_x      <= r_s6_minx;
            r_s7_box_y      <= r_s6_miny;
            r_s7_box_width  <= DATA_W'(r_s6_maxx) - DATA_W'(r_s6_minx);
            r_s7_box_height <= DATA_W'(r_s6_maxy) - DATA_W'(r_s6_miny);
        end
    end

    assign o_box.valid      = r_vld[NUM_STAGES-1];
    assign o_box.box_x      = r_s7_box_x;
    assign o_box.box_y      = r_s7_box_y;
    assign o_box.box_width  = r_s7_box_width;
    assign o_box.box_height = r_s7_box_height;

endmodule
`default_nettype wire

>>> rtl/arbb_checker.sv
`default_nettype none
module arbb_checker import arbb_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              in_valid,
    input wire              in_ready,
    input wire              out_valid,
    input wire              out_ready,
    input wire [DATA_W-1:0] box_x,
    input wire [DATA_W-1:0] box_y,
    input wire [DATA_W-1:0] box_width,
    input wire [DATA_W-1:0] box_height,
    input wire              psel,
    input wire              penable,
    input wire              pwrite,
    input wire [ADDR_W-1:0] paddr,
    input wire [DATA_W-1:0] pwdata,
    input wire [DATA_W-1:0] prdata,
    input wire              pready
);

    logic in_acc;
    logic cfg_wr;
    logic reg_ok;

    assign in_acc = in_valid && in_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_ok = paddr[ADDR_W-1:2] < IDX_W'(NUM_REGS);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(box_x) && $stable(box_y)
            && $stable(box_width) && $stable(box_height))
        else $error("stalled result changed");

    // with the output draining, an accepted item shows up after the pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
            ##1 out_ready |=> out_valid)
        else $error("accepted item did not reach the output");

    // no result while nothing could have entered since reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // a written register reads back
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr && reg_ok |=> (paddr != $past(paddr)) || (prdata == $past(pwdata)))
        else $error("register readback mismatch");

endmodule

bind affine_rect_bounding_box_core arbb_checker u_arbb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_rect.valid),
    .in_ready   (i_rect.ready),
    .out_valid  (o_box.valid),
    .out_ready  (o_box.ready),
    .box_x      (o_box.box_x),
    .box_y      (o_box.box_y),
    .box_width  (o_box.box_width),
    .box_height (o_box.box_height),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);
`default_nettype wire
